[rtl/core/icdp_pkg.sv]
// ----------------------------------------------------------------------------
// icdp_pkg
// Shared types, codes and constants of the icon directory parser.
// ----------------------------------------------------------------------------
package icdp_pkg;

  localparam int MAX_ENTRIES_DEFAULT = 65535;

  // Register indexes of the configuration port
  localparam logic CFG_SIZE_LIMIT = 1'b0;
  localparam logic CFG_FILE_SIZE  = 1'b1;

  localparam logic [8:0] SIZE_LIMIT_RESET = 9'd256;

  // Header is six bytes; position HDR_LEN means the entry table is running
  localparam logic [2:0] HDR_LEN        = 3'd6;
  localparam logic [2:0] HDR_RESERVED_HI = 3'd1;
  localparam logic [2:0] HDR_TYPE_HI     = 3'd3;
  localparam logic [2:0] HDR_COUNT_HI    = 3'd5;

  // Byte offsets within one 16-byte directory entry
  localparam logic [3:0] ENT_WIDTH   = 4'd0;
  localparam logic [3:0] ENT_HEIGHT  = 4'd1;
  localparam logic [3:0] ENT_LEN_END = 4'd11;
  localparam logic [3:0] ENT_OFF_END = 4'd15;

  localparam logic [15:0] ICON_TYPE = 16'd1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_RESERVED   = 3'd1,
    ST_NOT_ICON   = 3'd2,
    ST_ZERO_COUNT = 3'd3,
    ST_DIR_LONG   = 3'd4,
    ST_OUTSIDE    = 3'd5
  } icdp_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } icdp_in_t;

  typedef struct packed {
    icdp_status_t status;
    logic [15:0]  entry_index;
    logic [8:0]   width;
    logic [8:0]   height;
    logic [31:0]  image_offset;
    logic [31:0]  image_length;
  } icdp_out_t;

  // Per-byte commands from the sequencer to the selection unit
  typedef struct packed {
    logic clear;
    logic dims_en;
    logic len_en;
    logic off_en;
  } icdp_pick_ctrl_t;

  // Chosen entry as seen after the current byte
  typedef struct packed {
    logic [8:0]  width;
    logic [8:0]  height;
    logic [31:0] offset;
    logic [31:0] length;
  } icdp_pick_view_t;

  // A dimension byte of zero stands for 256
  function automatic logic [8:0] dim_of(input logic [7:0] b);
    return (b == 8'd0) ? 9'd256 : {1'b0, b};
  endfunction

endpackage

[rtl/core/icdp_best_pick.sv]
// ----------------------------------------------------------------------------
// icdp_best_pick
// Tracks the best fitting entry and the smallest-area fallback entry.
// ----------------------------------------------------------------------------
module icdp_best_pick #(
  parameter int IDX_W = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  icdp_pkg::icdp_pick_ctrl_t ctrl,
  input  logic [8:0]                size_limit,
  input  logic [8:0]                cand_width,
  input  logic [8:0]                cand_height,
  input  logic [IDX_W-1:0]          cand_idx,
  input  logic [31:0]               word,
  output logic [IDX_W-1:0]          sel_idx,
  output icdp_pkg::icdp_pick_view_t sel_view
);

  logic             take_best;
  logic             take_fb;
  logic             have_best;
  logic [16:0]      best_pixels;
  logic [16:0]      fb_area;

  logic [IDX_W-1:0] best_index;
  logic [8:0]       best_w;
  logic [8:0]       best_h;
  logic [31:0]      best_off;
  logic [31:0]      best_len;
  logic [IDX_W-1:0] fb_idx;
  logic [8:0]       fb_w;
  logic [8:0]       fb_h;
  logic [31:0]      fb_off;
  logic [31:0]      fb_len;

  logic [17:0]      prod;
  logic [16:0]      area;
  logic             fits;
  logic             tb;
  logic             tf;
  logic [31:0]      best_off_eff;
  logic [31:0]      fb_off_eff;

  assign prod = {9'd0, cand_width} * {9'd0, cand_height};
  assign area = prod[16:0];
  assign fits = (cand_width <= size_limit) && (cand_height <= size_limit);
  assign tb   = fits && (!have_best || (area > best_pixels));
  assign tf   = area < fb_area;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      take_best   <= 1'b0;
      take_fb     <= 1'b0;
      have_best   <= 1'b0;
      best_pixels <= '0;
      fb_area     <= '1;
    end else if (ctrl.dims_en) begin
      take_best <= tb;
      take_fb   <= tf;
      if (tb) begin
        have_best   <= 1'b1;
        best_pixels <= area;
      end
      if (tf) begin
        fb_area <= area;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.dims_en && tb) begin
      best_index <= cand_idx;
      best_w     <= cand_width;
      best_h     <= cand_height;
    end
    if (ctrl.dims_en && tf) begin
      fb_idx <= cand_idx;
      fb_w   <= cand_width;
      fb_h   <= cand_height;
    end
    if (ctrl.len_en && take_best) best_len <= word;
    if (ctrl.len_en && take_fb)   fb_len   <= word;
    if (ctrl.off_en && take_best) best_off <= word;
    if (ctrl.off_en && take_fb)   fb_off   <= word;
  end

  // Offset is the last field of an entry; show it before it lands
  assign best_off_eff = (ctrl.off_en && take_best) ? word : best_off;
  assign fb_off_eff   = (ctrl.off_en && take_fb)   ? word : fb_off;

  always_comb begin
    if (have_best) begin
      sel_idx         = best_index;
      sel_view.width  = best_w;
      sel_view.height = best_h;
      sel_view.offset = best_off_eff;
      sel_view.length = best_len;
    end else begin
      sel_idx         = fb_idx;
      sel_view.width  = fb_w;
      sel_view.height = fb_h;
      sel_view.offset = fb_off_eff;
      sel_view.length = fb_len;
    end
  end

endmodule

[rtl/core/icdp_parse_core.sv]
// ----------------------------------------------------------------------------
// icdp_parse_core
// Byte sequencer: header checks, entry field capture and final result.
// ----------------------------------------------------------------------------
module icdp_parse_core #(
  parameter int MAX_ENTRIES = icdp_pkg::MAX_ENTRIES_DEFAULT,
  parameter int IDX_W       = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  icdp_pkg::icdp_in_t  item,
  input  logic [8:0]          size_limit,
  input  logic [31:0]         file_size,
  output logic                res_valid,
  output icdp_pkg::icdp_out_t res
);

  logic             active;
  logic [2:0]       hdr_pos;
  logic [7:0]       hdr_lo;
  logic [15:0]      entry_count;
  logic [3:0]       entry_offset;
  logic [IDX_W-1:0] entry_number;
  logic [8:0]       entry_width;
  logic [31:0]      entry_field;

  logic             active_next;
  logic [2:0]       hdr_pos_next;
  logic [7:0]       hdr_lo_next;
  logic [15:0]      entry_count_next;
  logic [3:0]       entry_offset_next;
  logic [IDX_W-1:0] entry_number_next;
  logic [8:0]       entry_width_next;
  logic [31:0]      entry_field_next;

  logic [15:0]      hdr_word;
  logic [31:0]      dir_len;
  logic [31:0]      field_word;
  logic             last_entry;
  logic [32:0]      image_end;
  logic [8:0]       cand_height;

  icdp_pkg::icdp_pick_ctrl_t ctrl;
  icdp_pkg::icdp_pick_view_t sel_view;
  icdp_pkg::icdp_status_t    status;
  logic [IDX_W-1:0]          sel_idx;

  assign hdr_word    = {item.data_byte, hdr_lo};
  assign dir_len     = {12'd0, hdr_word, 4'b0110};
  assign field_word  = {item.data_byte, entry_field[31:8]};
  assign last_entry  = !((17'(entry_number) + 17'd1) < {1'b0, entry_count});
  assign image_end   = {1'b0, sel_view.offset} + {1'b0, sel_view.length};
  assign cand_height = icdp_pkg::dim_of(item.data_byte);

  always_comb begin
    active_next       = active;
    hdr_pos_next      = hdr_pos;
    hdr_lo_next       = hdr_lo;
    entry_count_next  = entry_count;
    entry_offset_next = entry_offset;
    entry_number_next = entry_number;
    entry_width_next  = entry_width;
    entry_field_next  = entry_field;
    ctrl              = '0;
    res_valid         = 1'b0;
    status            = icdp_pkg::ST_OK;
    if (step) begin
      if (item.first) begin
        // Restart: this byte is byte 0 of the header
        active_next       = 1'b1;
        hdr_pos_next      = 3'd1;
        hdr_lo_next       = item.data_byte;
        entry_offset_next = '0;
        entry_number_next = '0;
        ctrl.clear        = 1'b1;
      end else if (active) begin
        if (hdr_pos != icdp_pkg::HDR_LEN) begin
          hdr_pos_next = hdr_pos + 3'd1;
          if (!hdr_pos[0]) begin
            hdr_lo_next = item.data_byte;
          end else begin
            case (hdr_pos)
              icdp_pkg::HDR_RESERVED_HI: begin
                if (hdr_word != 16'd0) begin
                  res_valid = 1'b1;
                  status    = icdp_pkg::ST_RESERVED;
                end
              end
              icdp_pkg::HDR_TYPE_HI: begin
                if (hdr_word != icdp_pkg::ICON_TYPE) begin
                  res_valid = 1'b1;
                  status    = icdp_pkg::ST_NOT_ICON;
                end
              end
              icdp_pkg::HDR_COUNT_HI: begin
                entry_count_next = hdr_word;
                if (hdr_word == 16'd0) begin
                  res_valid = 1'b1;
                  status    = icdp_pkg::ST_ZERO_COUNT;
                end else if (hdr_word > 16'(MAX_ENTRIES) || dir_len > file_size) begin
                  res_valid = 1'b1;
                  status    = icdp_pkg::ST_DIR_LONG;
                end
              end
              default: ;
            endcase
          end
        end else begin
          entry_offset_next = entry_offset + 4'd1;
          if (entry_offset == icdp_pkg::ENT_WIDTH) begin
            entry_width_next = icdp_pkg::dim_of(item.data_byte);
          end
          if (entry_offset == icdp_pkg::ENT_HEIGHT) begin
            ctrl.dims_en = 1'b1;
          end
          // Shift little-endian bytes in from the top
          if (entry_offset[3]) begin
            entry_field_next = field_word;
          end
          if (entry_offset == icdp_pkg::ENT_LEN_END) begin
            ctrl.len_en = 1'b1;
          end
          if (entry_offset == icdp_pkg::ENT_OFF_END) begin
            ctrl.off_en = 1'b1;
            if (last_entry) begin
              res_valid = 1'b1;
              status    = (image_end > {1'b0, file_size}) ? icdp_pkg::ST_OUTSIDE
                                                          : icdp_pkg::ST_OK;
            end else begin
              entry_number_next = entry_number + 1'b1;
            end
          end
        end
        if (res_valid) begin
          active_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      hdr_pos      <= '0;
      entry_count  <= '0;
      entry_offset <= '0;
      entry_number <= '0;
    end else begin
      active       <= active_next;
      hdr_pos      <= hdr_pos_next;
      entry_count  <= entry_count_next;
      entry_offset <= entry_offset_next;
      entry_number <= entry_number_next;
    end
  end

  always_ff @(posedge clk) begin
    hdr_lo      <= hdr_lo_next;
    entry_width <= entry_width_next;
    entry_field <= entry_field_next;
  end

  icdp_best_pick #(
    .IDX_W(IDX_W)
  ) u_pick (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .size_limit (size_limit),
    .cand_width (entry_width),
    .cand_height(cand_height),
    .cand_idx   (entry_number),
    .word       (field_word),
    .sel_idx    (sel_idx),
    .sel_view   (sel_view)
  );

  always_comb begin
    res.status = status;
    if (status == icdp_pkg::ST_OK) begin
      res.entry_index  = 16'(sel_idx);
      res.width        = sel_view.width;
      res.height       = sel_view.height;
      res.image_offset = sel_view.offset;
      res.image_length = sel_view.length;
    end else begin
      res.entry_index  = '0;
      res.width        = '0;
      res.height       = '0;
      res.image_offset = '0;
      res.image_length = '0;
    end
  end

  a_emit_stops: assert property (@(posedge clk) disable iff (rst)
    step && res_valid |=> !active)
    else $error("parser still active after a result");

  a_entry_in_range: assert property (@(posedge clk) disable iff (rst)
    active && (hdr_pos == icdp_pkg::HDR_LEN) |->
      (17'(entry_number) < {1'b0, entry_count}))
    else $error("entry number ran past the directory count");

endmodule

[rtl/core/icon_directory_best_fit_parser.sv]
// ----------------------------------------------------------------------------
// icon_directory_best_fit_parser
// Streams an icon file byte by byte and reports the best-fit directory entry.
// ----------------------------------------------------------------------------
// Feed the file one byte per item, with first set on byte 0. The block takes
// one item every cycle while no result is stalled. Each item passes an input
// register, then combinational parse logic that updates the header/entry
// state and may load the result register. The per-byte path is bounded by
// the 9x9 area multiply and 17-bit area compare at the height byte, and by
// the 33-bit image-end add and compare at the last offset byte. A stalled
// result holds the result register; the input register still takes one more
// item, after which out_ready throttles in_ready directly. At most one result
// comes per file: on the first header error or after the last entry. Bytes
// are dropped until the next first flag. Write the size limit and file_size
// only while no file is in flight.
// ----------------------------------------------------------------------------
module icon_directory_best_fit_parser #(
  parameter int MAX_ENTRIES = icdp_pkg::MAX_ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  icdp_pkg::icdp_in_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output icdp_pkg::icdp_out_t out_item,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data
);

  // Index storage only needs to reach MAX_ENTRIES - 1
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [8:0]         size_limit;
  logic [31:0]        file_size;

  logic               inq_valid;
  icdp_pkg::icdp_in_t inq_item;
  logic               consume;
  logic               res_valid;
  logic               res_load;
  icdp_pkg::icdp_out_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= icdp_pkg::SIZE_LIMIT_RESET;
      file_size  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        icdp_pkg::CFG_SIZE_LIMIT: size_limit <= cfg_data[8:0];
        icdp_pkg::CFG_FILE_SIZE:  file_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the held item whenever the result slot is free or draining
  assign consume  = inq_valid && (!out_valid || out_ready);
  assign in_ready = !inq_valid || consume;
  assign res_load = consume && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_item <= in_item;
    end
  end

  icdp_parse_core #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .IDX_W      (IDX_W)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (consume),
    .item      (inq_item),
    .size_limit(size_limit),
    .file_size (file_size),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_item <= res;
    end
  end

  a_load_free_slot: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken item");

  a_error_zeroes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status != icdp_pkg::ST_OK) |->
      (out_item.entry_index == 16'd0) && (out_item.width == 9'd0) &&
      (out_item.height == 9'd0) && (out_item.image_offset == 32'd0) &&
      (out_item.image_length == 32'd0))
    else $error("error result carries entry data");

  a_ok_dims: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status == icdp_pkg::ST_OK) |->
      (out_item.width != 9'd0) && (out_item.height != 9'd0) &&
      (out_item.width <= 9'd256) && (out_item.height <= 9'd256))
    else $error("chosen entry dimensions out of range");

endmodule

[tb/icon_directory_best_fit_parser_tb.sv]
// ----------------------------------------------------------------------------
// icon_directory_best_fit_parser_tb
// Self-checking bench for the icon directory best-fit parser. Icon files are
// built byte by byte, some well formed and some with broken or truncated
// headers, and streamed through the input channel. Random gaps on both sides
// and one long receiver hold-off are applied. Register settings range over
// the extremes of the size limit and file_size. A scoreboard tracks the parse
// state of every accepted item and compares each result field by field.
// ----------------------------------------------------------------------------
module icon_directory_best_fit_parser_tb;

  localparam int IDLE_LIMIT   = 4000;  // cycles with no item moving on either side
  localparam int HOLD_CYCLES  = 400;   // receiver hold-off that backs the block up
  localparam int DRAIN_CYCLES = 8;     // covers the input and result registers

  typedef logic [7:0] byte_q_t[$];

  // Chosen directory entry: index, size, offset and length
  typedef struct packed {
    logic [15:0] idx;
    logic [8:0]  w;
    logic [8:0]  h;
    logic [31:0] off;
    logic [31:0] len;
  } pick_rec_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the parse of each accepted item and holds the picks
  // that the block still owes.
  // --------------------------------------------------------------------------
  class icon_pick_board;
    logic [8:0]  size_limit;
    logic [31:0] file_size;

    logic [20:0] pos;
    bit          active;
    logic [15:0] count;
    logic [15:0] hword;
    logic [15:0] ent_num;
    logic [8:0]  ew;
    logic [8:0]  eh;
    logic [31:0] efield;
    bit          to_best;
    bit          to_fb;
    bit          have_best;
    pick_rec_t   best;
    pick_rec_t   fb;
    logic [16:0] best_pixels;
    logic [16:0] fb_area;

    icdp_pkg::icdp_out_t pending_picks[$];
    int                  mismatches;
    int                  results_due;
    int                  status_hits[6];

    function new();
      size_limit  = icdp_pkg::SIZE_LIMIT_RESET;
      file_size   = '0;
      active      = 0;
      mismatches  = 0;
      results_due = 0;
      start_file();
    endfunction

    function void start_file();
      pos         = '0;
      count       = '0;
      hword       = '0;
      ent_num     = '0;
      ew          = '0;
      eh          = '0;
      efield      = '0;
      to_best     = 0;
      to_fb       = 0;
      have_best   = 0;
      best        = '0;
      best_pixels = '0;
      fb          = '0;
      fb_area     = '1;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == icdp_pkg::CFG_SIZE_LIMIT) size_limit = val[8:0];
      else file_size = val;
    endfunction

    function logic [8:0] dim(logic [7:0] b);
      return (b == 8'd0) ? 9'd256 : {1'b0, b};
    endfunction

    function void finish_file(icdp_pkg::icdp_status_t st, pick_rec_t r);
      icdp_pkg::icdp_out_t res;
      active           = 0;
      res.status       = st;
      res.entry_index  = r.idx;
      res.width        = r.w;
      res.height       = r.h;
      res.image_offset = r.off;
      res.image_length = r.len;
      pending_picks.push_back(res);
      results_due++;
      status_hits[int'(st)]++;
    endfunction

    // Note one accepted item and advance the parse
    function void take_byte(icdp_pkg::icdp_in_t it);
      logic [7:0]  b;
      logic [20:0] p;
      logic [3:0]  o;
      logic [1:0]  k;
      logic [16:0] area;
      logic [32:0] img_end;
      bit          fits;
      pick_rec_t   none;
      pick_rec_t   c;
      b    = it.data_byte;
      none = '0;
      if (it.first) begin
        start_file();
        active = 1;
      end else if (!active) begin
        return;
      end
      p   = pos;
      pos = p + 21'd1;

      if (p < 21'd6) begin
        if (!p[0]) begin
          hword = {8'h00, b};
          return;
        end
        hword[15:8] = b;
        if (p == 21'd1 && hword != 16'd0) begin
          finish_file(icdp_pkg::ST_RESERVED, none);
        end else if (p == 21'd3 && hword != icdp_pkg::ICON_TYPE) begin
          finish_file(icdp_pkg::ST_NOT_ICON, none);
        end else if (p == 21'd5) begin
          count = hword;
          if (count == 16'd0) begin
            finish_file(icdp_pkg::ST_ZERO_COUNT, none);
          end else if (int'(count) > icdp_pkg::MAX_ENTRIES_DEFAULT ||
                       64'd6 + 64'd16 * count > {32'd0, file_size}) begin
            finish_file(icdp_pkg::ST_DIR_LONG, none);
          end
        end
        return;
      end

      o = 4'(p - 21'd6);
      if (o == 4'd0) begin
        ew = dim(b);
      end else if (o == 4'd1) begin
        eh      = dim(b);
        area    = {8'd0, ew} * {8'd0, eh};
        fits    = (ew <= size_limit) && (eh <= size_limit);
        to_best = fits && (!have_best || area > best_pixels);
        to_fb   = area < fb_area;
        if (to_best) begin
          have_best   = 1;
          best_pixels = area;
          best.idx    = ent_num;
          best.w      = ew;
          best.h      = eh;
        end
        if (to_fb) begin
          fb_area = area;
          fb.idx  = ent_num;
          fb.w    = ew;
          fb.h    = eh;
        end
      end else if (o >= 4'd8) begin
        k = 2'(o - 4'd8);
        if (k == 2'd0) efield = '0;
        efield = efield | (32'(b) << (8 * k));
        if (o == 4'd11) begin
          if (to_best) best.len = efield;
          if (to_fb) fb.len = efield;
        end else if (o == 4'd15) begin
          if (to_best) best.off = efield;
          if (to_fb) fb.off = efield;
          if (int'(ent_num) + 1 < int'(count)) begin
            ent_num++;
          end else begin
            c       = have_best ? best : fb;
            img_end = {1'b0, c.off} + {1'b0, c.len};
            if (img_end > {1'b0, file_size}) finish_file(icdp_pkg::ST_OUTSIDE, none);
            else finish_file(icdp_pkg::ST_OK, c);
          end
        end
      end
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one accepted result against the oldest pick owed
    function void match_pick(icdp_pkg::icdp_out_t got);
      icdp_pkg::icdp_out_t want;
      if (pending_picks.size() == 0) begin
        $error("result with none owed: status %0d index %0d", got.status, got.entry_index);
        mismatches++;
        return;
      end
      want = pending_picks.pop_front();
      cmp_field("status", 32'(want.status), 32'(got.status));
      cmp_field("entry_index", 32'(want.entry_index), 32'(got.entry_index));
      cmp_field("width", 32'(want.width), 32'(got.width));
      cmp_field("height", 32'(want.height), 32'(got.height));
      cmp_field("image_offset", want.image_offset, got.image_offset);
      cmp_field("image_length", want.image_length, got.image_length);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  icdp_pkg::icdp_in_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  icdp_pkg::icdp_out_t out_item;
  logic                cfg_we    = 1'b0;
  logic                cfg_index = icdp_pkg::CFG_SIZE_LIMIT;
  logic [31:0]         cfg_data  = '0;

  icon_directory_best_fit_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  icon_pick_board board;
  bit calm;           // no gaps on either side while set
  bit hold_req;       // asks the receiver for one long hold-off
  int items_sent;
  int files_sent;
  int settings_used;
  int idle_cycles;

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put16(ref byte_q_t q, input logic [15:0] v);
    q.push_back(v[7:0]);
    q.push_back(v[15:8]);
  endfunction

  function automatic void put32(ref byte_q_t q, input logic [31:0] v);
    put16(q, v[15:0]);
    put16(q, v[31:16]);
  endfunction

  // Dimension byte: favor 0 (256), the ends and values around the size limit
  function automatic logic [7:0] pick_dim(input logic [8:0] msz);
    int r;
    int t;
    r = $urandom_range(0, 99);
    if (r < 20) return 8'd0;
    if (r < 30) return 8'd255;
    if (r < 40) return 8'd1;
    if (r < 60) begin
      t = int'(msz) + int'($urandom_range(0, 2)) - 1;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
      return 8'(t);
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Build one file. Most are well formed with random entries; the rest carry
  // header errors, an oversized directory or stop part way through.
  function automatic byte_q_t build_file(input logic [8:0] msz, input logic [31:0] fsz,
                                         input bit tiny);
    byte_q_t     q;
    int          r;
    int          r2;
    int          n;
    int          nmax;
    longint      nmin;
    logic [15:0] v;
    logic [31:0] off;
    logic [31:0] len;
    logic [7:0]  w;
    logic [7:0]  h;
    logic [7:0]  pw;
    logic [7:0]  ph;
    q    = {};
    pw   = 8'd0;
    ph   = 8'd0;
    r    = tiny ? 0 : $urandom_range(0, 99);
    nmax = (fsz < 32'd22) ? 0 : (((fsz - 32'd6) / 32'd16 > 32'd64) ? 64 :
                                 int'((fsz - 32'd6) / 32'd16));
    if (nmax == 0 && r < 70) r = $urandom_range(70, 99);

    if (r < 70) begin
      r2 = $urandom_range(0, 9);
      n  = (r2 < 6) ? $urandom_range(1, 3) : (r2 < 9) ? $urandom_range(4, 8) :
           $urandom_range(9, 24);
      if (tiny) n = 1;
      if (n > nmax) n = nmax;
      put16(q, 16'd0);
      put16(q, icdp_pkg::ICON_TYPE);
      put16(q, 16'(n));
      for (int e = 0; e < n; e++) begin
        // Repeat or swap the previous size now and then to force area ties
        if (e > 0 && $urandom_range(0, 5) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            w = pw;
            h = ph;
          end else begin
            w = ph;
            h = pw;
          end
        end else begin
          w = pick_dim(msz);
          h = pick_dim(msz);
        end
        q.push_back(w);
        q.push_back(h);
        repeat (6) q.push_back(8'($urandom));
        r2 = $urandom_range(0, 99);
        if (r2 < 60) begin
          off = $urandom_range(0, fsz);
          len = $urandom_range(0, fsz - off);
        end else if (r2 < 75) begin
          // one byte past the end
          len = $urandom_range(1, 64);
          off = fsz - len + 32'd1;
        end else if (r2 < 85) begin
          // ends exactly at the end
          len = $urandom_range(0, 64);
          off = fsz - len;
        end else begin
          off = $urandom;
          len = $urandom;
        end
        put32(q, len);
        put32(q, off);
        pw = w;
        ph = h;
      end
    end else if (r < 78) begin
      put16(q, 16'($urandom_range(1, 65535)));
    end else if (r < 85) begin
      v = 16'($urandom);
      if (v == icdp_pkg::ICON_TYPE) v = 16'hFFFF;
      put16(q, 16'd0);
      put16(q, v);
    end else if (r < 90) begin
      put16(q, 16'd0);
      put16(q, icdp_pkg::ICON_TYPE);
      put16(q, 16'd0);
    end else if (r < 95) begin
      // smallest count that overflows file_size, or any count above it
      nmin = (fsz < 32'd6) ? 1 : (longint'(fsz) - 6) / 16 + 1;
      if (nmin > 65535) v = 16'($urandom_range(1, 65535));
      else if ($urandom_range(0, 1) == 0) v = 16'(nmin);
      else v = 16'($urandom_range(int'(nmin), 65535));
      put16(q, 16'd0);
      put16(q, icdp_pkg::ICON_TYPE);
      put16(q, v);
    end else begin
      // valid start, arbitrary count, cut short by the next file
      put16(q, 16'd0);
      put16(q, icdp_pkg::ICON_TYPE);
      put16(q, 16'($urandom));
      repeat ($urandom_range(0, 40)) q.push_back(8'($urandom));
    end
    return q;
  endfunction

  // Offer one item and hold it until accepted. Sample ready on the falling
  // edge so the accepting rising edge is known without racing the block.
  task automatic send_byte(input logic [7:0] b, input bit f);
    int                 gap;
    icdp_pkg::icdp_in_t it;
    gap          = pick_gap();
    it.data_byte = b;
    it.first     = f;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    board.take_byte(it);
    @(posedge clk);
  endtask

  // Stream a file; with restarts set, a stray first flag may land mid-file
  task automatic send_file(input byte_q_t q, input bit restarts);
    bit f;
    foreach (q[i]) begin
      f = (i == 0) || (restarts && $urandom_range(0, 399) == 0);
      send_byte(q[i], f);
      items_sent++;
    end
    files_sent++;
  endtask

  // Let the block go idle, then write both registers
  task automatic load_regs(input logic [8:0] msz, input logic [31:0] fsz);
    in_valid <= 1'b0;
    while (board.pending_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= icdp_pkg::CFG_SIZE_LIMIT;
    cfg_data  <= {23'd0, msz};
    @(posedge clk);
    cfg_index <= icdp_pkg::CFG_FILE_SIZE;
    cfg_data  <= fsz;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(icdp_pkg::CFG_SIZE_LIMIT, {23'd0, msz});
    board.set_reg(icdp_pkg::CFG_FILE_SIZE, fsz);
    settings_used++;
  endtask

  // Check every result taken on the next rising edge
  always @(negedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) board.match_pick(out_item);
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus
  initial begin
    byte_q_t     q;
    int          phase;
    int          start;
    int          r;
    logic [8:0]  msz;
    logic [31:0] fsz;
    board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset register values first (size limit 256, file_size 0)
    send_byte(8'hA5, 1'b0);                              // idle byte, dropped
    send_file('{8'h00, 8'h80}, 1'b0);                    // reserved nonzero
    send_file('{8'h00, 8'h00, 8'h02, 8'h00}, 1'b0);      // type not icon
    send_file('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00}, 1'b0);  // zero count
    send_file('{8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00}, 1'b0);  // too long for 0
    load_regs(9'd256, 32'd200);
    send_file('{8'h00, 8'h00, 8'h01}, 1'b0);             // dropped by next first flag
    // one 256x256 entry, 16 bytes at offset 22
    send_file('{8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00,
                8'h00, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h00, 8'h20, 8'h00,
                8'h10, 8'h00, 8'h00, 8'h00, 8'h16, 8'h00, 8'h00, 8'h00}, 1'b0);

    // Random phases, one register setting each
    phase = 0;
    while (items_sent < 1000 || board.results_due < 60) begin
      case (phase)
        0: begin msz = 9'd0;   fsz = 32'd512; end
        1: begin msz = 9'h1FF; fsz = 32'hFFFF_FFFF; end
        2: begin msz = 9'd256; fsz = 32'd22; end
        3: begin msz = 9'd256; fsz = 32'd21; end
        4: begin msz = 9'd1;   fsz = 32'd0; end
        5: begin msz = 9'd256; fsz = 32'd1024; end
        default: begin
          r = $urandom_range(0, 7);
          msz = (r == 0) ? 9'd0 : (r == 1) ? 9'd1 : (r == 2) ? 9'd255 :
                (r == 3) ? 9'd256 : (r == 4) ? 9'($urandom_range(257, 511)) :
                9'($urandom_range(0, 256));
          r = $urandom_range(0, 99);
          fsz = (r < 30) ? 32'(22 + 16 * $urandom_range(0, 30) + $urandom_range(0, 1)) :
                (r < 60) ? 32'($urandom_range(22, 4096)) :
                (r < 80) ? 32'($urandom) : 32'hFFFF_FFFF;
        end
      endcase
      load_regs(msz, fsz);
      calm = (phase % 5 == 4);

      // Back the block up: hold the receiver while minimal files keep coming
      if (phase == 2) begin
        calm     = 1;
        hold_req = 1;
        repeat (12) send_file(build_file(msz, fsz, 1'b1), 1'b0);
        calm = 0;
      end

      start = items_sent;
      while (items_sent - start < 120) begin
        q = build_file(msz, fsz, 1'b0);
        send_file(q, 1'b1);
        // trailing bytes with no first flag; dropped once the file is done
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0);
        end
      end
      phase++;
    end

    // Drain: wait for every owed result, then a little longer for strays
    in_valid <= 1'b0;
    calm = 0;
    while (board.pending_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d file items in %0d files over %0d register settings",
             items_sent, files_sent, settings_used);
    $display("Results: %0d ok, %0d reserved, %0d not icon, %0d zero count,",
             board.status_hits[0], board.status_hits[1], board.status_hits[2],
             board.status_hits[3]);
    $display("         %0d too long, %0d outside",
             board.status_hits[4], board.status_hits[5]);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
